// ===== sv/sample_loop_cursor_core_assert.svh =====
// Assertion macros shared by the sample loop cursor modules.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef SAMPLE_LOOP_CURSOR_CORE_ASSERT_SVH
`define SAMPLE_LOOP_CURSOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define SLC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sample_loop_cursor_core: same-cycle check failed");

// Next-cycle implication.
`define SLC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sample_loop_cursor_core: next-cycle check failed");

`endif

// ===== sv/slc_pkg.sv =====
package slc_pkg;

    localparam int MAX_WRAPS  = 64;
    localparam int FRAC_BITS  = 16;
    localparam int INDEX_BITS = 24;
    localparam int INC_BITS   = 24;
    localparam int POS_BITS   = INDEX_BITS + FRAC_BITS;
    // Working position: signed, with headroom for reflections past either bound.
    localparam int WORK_BITS  = POS_BITS + 4;
    localparam int GUARD_BITS = $clog2(MAX_WRAPS + 1);

    localparam int MODE_BITS  = 2;
    localparam logic [MODE_BITS-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_FWD  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_PP   = 2'd2;

    localparam int PADDR_BITS = 5;
    localparam int PDATA_BITS = 32;
    localparam int REG_BITS   = 3;
    localparam logic [REG_BITS-1:0] REG_LOOP_MODE   = 3'd0;
    localparam logic [REG_BITS-1:0] REG_INTRO_EN    = 3'd1;
    localparam logic [REG_BITS-1:0] REG_LOOP_START  = 3'd2;
    localparam logic [REG_BITS-1:0] REG_LOOP_END    = 3'd3;
    localparam logic [REG_BITS-1:0] REG_RELEASE_END = 3'd4;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_INTRO,
        CMD_ADVANCE,
        CMD_WRAP,
        CMD_COMMIT
    } cmd_t;

    typedef struct packed {
        logic loop_path;
        logic intro_hit;
        logic below_hi;
        logic need_wrap;
        logic out_free;
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_PREP      = 5'b00010,
        S_INTRO_CHK = 5'b00100,
        S_WRAP      = 5'b01000,
        S_COMMIT    = 5'b10000
    } state_t;

endpackage

// ===== sv/sample_loop_cursor_core.sv =====
// Sample loop cursor: advances one voice's Q24.16 read position per input beat.
// Input channel (in_valid/in_stall) carries increment (Q8.16) and released;
// a beat is taken when in_valid is high and in_stall is low. Output channel
// (out_valid/out_stall) carries read_position, moving_backward and finished;
// the receiver holds out_stall high to keep a beat, which then stays unchanged.
// The user must write loop registers through the APB port only while no beat
// is in flight; the block does not check it. A beat is taken only after the
// last is committed. When looping, the 44-bit datapath does one wrap or
// reflection per cycle, up to 64 of them, before the commit. The output beat
// appears in the cycle after the commit. While a result waits in the output
// register, the next beat is still taken and worked on; its commit waits until
// the waiting beat leaves. Reset clears the cursor to zero, moving forward, and
// loads the register reset values (no loop, end indices of one).
module sample_loop_cursor_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [slc_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [slc_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [slc_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [slc_pkg::INC_BITS-1:0]      increment,
    input  logic                              released,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [slc_pkg::POS_BITS-1:0]      read_position,
    output logic                              moving_backward,
    output logic                              finished
);

    logic [slc_pkg::MODE_BITS-1:0]  loop_mode_reg;
    logic                           intro_enable_reg;
    logic [slc_pkg::INDEX_BITS-1:0] loop_start_reg;
    logic [slc_pkg::INDEX_BITS-1:0] loop_end_reg;
    logic [slc_pkg::INDEX_BITS-1:0] release_end_reg;
    logic [slc_pkg::REG_BITS-1:0]   reg_index;
    logic                           cfg_write;

    slc_pkg::cmd_t    cmd;
    slc_pkg::status_t status;

    assign pready    = 1'b1;
    assign reg_index = paddr[slc_pkg::PADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_mode_reg    <= slc_pkg::MODE_NONE;
            intro_enable_reg <= 1'b0;
            loop_start_reg   <= '0;
            loop_end_reg     <= slc_pkg::INDEX_BITS'(1);
            release_end_reg  <= slc_pkg::INDEX_BITS'(1);
        end
        else if (cfg_write)
        begin
            case (reg_index)
                slc_pkg::REG_LOOP_MODE:   loop_mode_reg    <= pwdata[slc_pkg::MODE_BITS-1:0];
                slc_pkg::REG_INTRO_EN:    intro_enable_reg <= pwdata[0];
                slc_pkg::REG_LOOP_START:  loop_start_reg   <= pwdata[slc_pkg::INDEX_BITS-1:0];
                slc_pkg::REG_LOOP_END:    loop_end_reg     <= pwdata[slc_pkg::INDEX_BITS-1:0];
                slc_pkg::REG_RELEASE_END: release_end_reg  <= pwdata[slc_pkg::INDEX_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            slc_pkg::REG_LOOP_MODE:
                prdata = slc_pkg::PDATA_BITS'(loop_mode_reg);
            slc_pkg::REG_INTRO_EN:
                prdata = slc_pkg::PDATA_BITS'(intro_enable_reg);
            slc_pkg::REG_LOOP_START:
                prdata = slc_pkg::PDATA_BITS'(loop_start_reg);
            slc_pkg::REG_LOOP_END:
                prdata = slc_pkg::PDATA_BITS'(loop_end_reg);
            slc_pkg::REG_RELEASE_END:
                prdata = slc_pkg::PDATA_BITS'(release_end_reg);
            default:
                prdata = '0;
        endcase
    end

    slc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    slc_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .loop_mode         (loop_mode_reg),
        .intro_enable      (intro_enable_reg),
        .loop_start_index  (loop_start_reg),
        .loop_end_index    (loop_end_reg),
        .release_end_index (release_end_reg),
        .increment         (increment),
        .released          (released),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .read_position     (read_position),
        .moving_backward   (moving_backward),
        .finished          (finished)
    );

endmodule

// ===== sv/slc_ctrl.sv =====
`include "sample_loop_cursor_core_assert.svh"

module slc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  slc_pkg::status_t status,
    output slc_pkg::cmd_t    cmd
);

    slc_pkg::state_t state_reg;
    slc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = slc_pkg::CMD_NONE;
        case (state_reg)
            slc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = slc_pkg::CMD_LOAD;
                    state_next = slc_pkg::S_PREP;
                end
            end
            slc_pkg::S_PREP:
            begin
                if (status.intro_hit)
                begin
                    cmd        = slc_pkg::CMD_INTRO;
                    state_next = slc_pkg::S_INTRO_CHK;
                end
                else
                begin
                    cmd        = slc_pkg::CMD_ADVANCE;
                    state_next = status.loop_path ? slc_pkg::S_WRAP : slc_pkg::S_COMMIT;
                end
            end
            slc_pkg::S_INTRO_CHK:
            begin
                // An intro step that stays below loop end is the whole step.
                if (status.below_hi)
                begin
                    state_next = slc_pkg::S_COMMIT;
                end
                else
                begin
                    cmd        = slc_pkg::CMD_ADVANCE;
                    state_next = slc_pkg::S_WRAP;
                end
            end
            slc_pkg::S_WRAP:
            begin
                if (status.need_wrap)
                begin
                    cmd = slc_pkg::CMD_WRAP;
                end
                else
                begin
                    state_next = slc_pkg::S_COMMIT;
                end
            end
            slc_pkg::S_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd        = slc_pkg::CMD_COMMIT;
                    state_next = slc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = slc_pkg::S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != slc_pkg::S_IDLE);

    `SLC_ASSERT_NXT(a_accept_to_prep, in_valid && !in_stall, state_reg == slc_pkg::S_PREP)
    `SLC_ASSERT_IMP(a_commit_free, cmd == slc_pkg::CMD_COMMIT, status.out_free)
    `SLC_ASSERT_IMP(a_wrap_in_loop, cmd == slc_pkg::CMD_WRAP, status.loop_path)

endmodule

// ===== sv/slc_datapath.sv =====
`include "sample_loop_cursor_core_assert.svh"

module slc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  slc_pkg::cmd_t                     cmd,
    output slc_pkg::status_t                  status,
    input  logic [slc_pkg::MODE_BITS-1:0]     loop_mode,
    input  logic                              intro_enable,
    input  logic [slc_pkg::INDEX_BITS-1:0]    loop_start_index,
    input  logic [slc_pkg::INDEX_BITS-1:0]    loop_end_index,
    input  logic [slc_pkg::INDEX_BITS-1:0]    release_end_index,
    input  logic [slc_pkg::INC_BITS-1:0]      increment,
    input  logic                              released,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [slc_pkg::POS_BITS-1:0]      read_position,
    output logic                              moving_backward,
    output logic                              finished
);

    localparam int W  = slc_pkg::WORK_BITS;
    localparam int IB = slc_pkg::INDEX_BITS;
    localparam int FB = slc_pkg::FRAC_BITS;
    localparam logic [slc_pkg::GUARD_BITS-1:0] GUARD_MAX =
        slc_pkg::GUARD_BITS'(slc_pkg::MAX_WRAPS);

    // Per-item working registers.
    logic [slc_pkg::INC_BITS-1:0]   inc_reg;
    logic                           free_reg;
    logic signed [W-1:0]            work_reg;
    logic signed [W-1:0]            work_next;
    logic                           bwd_reg;
    logic                           bwd_next;
    logic [slc_pkg::GUARD_BITS-1:0] guard_reg;
    logic signed [W-1:0]            lo_reg;
    logic signed [W-1:0]            hi_reg;
    logic signed [W-1:0]            span_reg;

    // Voice state and output beat.
    logic [slc_pkg::POS_BITS-1:0]   cursor_reg;
    logic                           backward_reg;
    logic                           fin_reg;
    logic                           out_valid_reg;

    logic                           mode_fwd;
    logic                           mode_none;
    logic [IB:0]                    start_p1;
    logic [IB:0]                    end_ext;
    logic [IB:0]                    eff_end;
    logic signed [W-1:0]            inc_ext;
    logic signed [W-1:0]            rel_ext;
    logic                           eff_bwd;
    logic                           at_or_above_hi;
    logic                           below_lo;
    logic [slc_pkg::POS_BITS-1:0]   clamped;

    assign mode_fwd  = (loop_mode == slc_pkg::MODE_FWD);
    assign mode_none = (loop_mode == slc_pkg::MODE_NONE);

    assign start_p1 = {1'b0, loop_start_index} + {{IB{1'b0}}, 1'b1};
    assign end_ext  = {1'b0, loop_end_index};
    assign eff_end  = (end_ext < start_p1) ? start_p1 : end_ext;

    assign inc_ext = signed'({{(W - slc_pkg::INC_BITS){1'b0}}, inc_reg});
    assign rel_ext = signed'({{(W - IB - FB){1'b0}}, release_end_index, {FB{1'b0}}});

    assign at_or_above_hi = (work_reg >= hi_reg);
    assign below_lo       = (work_reg < lo_reg);

    // Free running drops the backward flag in ping-pong modes; forward
    // looping always runs forward.
    always_comb
    begin
        if (free_reg)
        begin
            eff_bwd = bwd_reg && (mode_none || mode_fwd);
        end
        else
        begin
            eff_bwd = bwd_reg && !mode_fwd;
        end
    end

    always_comb
    begin
        work_next = work_reg;
        bwd_next  = bwd_reg;
        case (cmd)
            slc_pkg::CMD_INTRO:
            begin
                work_next = work_reg + inc_ext;
                bwd_next  = 1'b0;
            end
            slc_pkg::CMD_ADVANCE:
            begin
                work_next = eff_bwd ? (work_reg - inc_ext) : (work_reg + inc_ext);
                bwd_next  = eff_bwd;
            end
            slc_pkg::CMD_WRAP:
            begin
                if (mode_fwd)
                begin
                    work_next = work_reg - span_reg;
                    bwd_next  = 1'b0;
                end
                else if (at_or_above_hi)
                begin
                    work_next = (hi_reg <<< 1) - work_reg;
                    bwd_next  = 1'b1;
                end
                else
                begin
                    work_next = (lo_reg <<< 1) - work_reg;
                    bwd_next  = 1'b0;
                end
            end
            default:
            begin
                work_next = work_reg;
                bwd_next  = bwd_reg;
            end
        endcase
    end

    always_comb
    begin
        if (work_reg < 0)
        begin
            clamped = '0;
        end
        else if (|work_reg[W-1:slc_pkg::POS_BITS])
        begin
            clamped = '1;
        end
        else
        begin
            clamped = work_reg[slc_pkg::POS_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= hi_reg - lo_reg;
        if (cmd == slc_pkg::CMD_LOAD)
        begin
            inc_reg   <= (increment == '0) ? slc_pkg::INC_BITS'(1) : increment;
            free_reg  <= mode_none || released;
            work_reg  <= signed'({{(W - slc_pkg::POS_BITS){1'b0}}, cursor_reg});
            bwd_reg   <= backward_reg;
            lo_reg    <= signed'({{(W - IB - FB){1'b0}}, loop_start_index, {FB{1'b0}}});
            hi_reg    <= signed'({{(W - IB - FB - 1){1'b0}}, eff_end, {FB{1'b0}}});
        end
        else
        begin
            work_reg <= work_next;
            bwd_reg  <= bwd_next;
            if (cmd == slc_pkg::CMD_COMMIT)
            begin
                fin_reg <= free_reg && (work_reg >= rel_ext);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            backward_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            guard_reg     <= '0;
        end
        else
        begin
            if (cmd == slc_pkg::CMD_LOAD)
            begin
                guard_reg <= '0;
            end
            else if (cmd == slc_pkg::CMD_WRAP)
            begin
                guard_reg <= slc_pkg::GUARD_BITS'(guard_reg + 1'b1);
            end
            if (cmd == slc_pkg::CMD_COMMIT)
            begin
                cursor_reg    <= clamped;
                backward_reg  <= bwd_reg;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.loop_path = !free_reg;
    assign status.intro_hit = !free_reg && intro_enable && below_lo;
    assign status.below_hi  = !at_or_above_hi;
    assign status.need_wrap = !free_reg && (guard_reg < GUARD_MAX) &&
                              (at_or_above_hi || (!mode_fwd && below_lo));
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign read_position   = cursor_reg;
    assign moving_backward = backward_reg;
    assign finished        = fin_reg;

    `SLC_ASSERT_IMP(a_guard_bound, 1'b1, guard_reg <= GUARD_MAX)
    `SLC_ASSERT_NXT(a_commit_valid, cmd == slc_pkg::CMD_COMMIT, out_valid_reg)
    `SLC_ASSERT_NXT(a_loop_not_finished, cmd == slc_pkg::CMD_COMMIT && !free_reg, !fin_reg)

endmodule

// ===== bench/cursor_position_checker.sv =====
`timescale 1ns / 1ps

// Watches the register port and both beat channels, keeps its own copy of the
// loop registers and of the cursor, and checks every output beat in order.
module cursor_position_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [slc_pkg::PADDR_BITS-1:0] paddr,
    input  logic [slc_pkg::PDATA_BITS-1:0] pwdata,
    input  logic                           pready,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [slc_pkg::INC_BITS-1:0]   increment,
    input  logic                           released,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [slc_pkg::POS_BITS-1:0]   read_position,
    input  logic                           moving_backward,
    input  logic                           finished,
    output int unsigned                    errors,
    output int unsigned                    outstanding
);

    localparam longint POS_LIMIT = (64'sd1 <<< slc_pkg::POS_BITS) - 1;

    typedef struct packed {
        logic [slc_pkg::POS_BITS-1:0] position;
        logic                         backward;
        logic                         done;
    } cursor_beat_t;

    cursor_beat_t expected_positions[$];
    cursor_beat_t want;
    cursor_beat_t predicted;

    logic [slc_pkg::MODE_BITS-1:0]  loop_mode;
    logic                           intro_on;
    logic [slc_pkg::INDEX_BITS-1:0] start_idx;
    logic [slc_pkg::INDEX_BITS-1:0] end_idx;
    logic [slc_pkg::INDEX_BITS-1:0] rel_end_idx;
    logic [slc_pkg::POS_BITS-1:0]   cursor_pos;
    logic                           cursor_back;

    // Moves the cursor by one step and returns the beat the block must produce.
    function automatic cursor_beat_t advance_cursor(
        input logic [slc_pkg::INC_BITS-1:0] step_in,
        input logic                         rel
    );
        longint step;
        longint pos;
        longint lo;
        longint hi;
        longint nxt;
        longint top_idx;
        longint rel_lim;
        int wraps;
        logic looping;
        cursor_beat_t beat;

        step = longint'(step_in);
        if (step == 0)
            step = 1;
        pos = longint'(cursor_pos);
        beat.done = 1'b0;

        if (loop_mode != slc_pkg::MODE_NONE && !rel)
        begin
            lo = longint'(start_idx);
            top_idx = longint'(end_idx);
            if (top_idx < lo + 1)
                top_idx = lo + 1;
            lo = lo << slc_pkg::FRAC_BITS;
            hi = top_idx << slc_pkg::FRAC_BITS;
            looping = 1'b1;

            // The intro runs straight up; crossing the loop end also applies
            // the loop step below, so the cursor moves twice.
            if (intro_on && pos < lo)
            begin
                nxt = pos + step;
                cursor_back = 1'b0;
                if (nxt < hi)
                begin
                    pos = nxt;
                    looping = 1'b0;
                end
                else
                begin
                    pos = (nxt > lo) ? nxt : lo;
                end
            end

            if (looping)
            begin
                wraps = 0;
                if (loop_mode == slc_pkg::MODE_FWD)
                begin
                    nxt = pos + step;
                    while (nxt >= hi && wraps < slc_pkg::MAX_WRAPS)
                    begin
                        wraps++;
                        nxt = lo + (nxt - hi);
                    end
                    pos = nxt;
                    cursor_back = 1'b0;
                end
                else
                begin
                    nxt = cursor_back ? pos - step : pos + step;
                    while ((nxt >= hi || nxt < lo) && wraps < slc_pkg::MAX_WRAPS)
                    begin
                        wraps++;
                        if (nxt >= hi)
                        begin
                            nxt = hi - (nxt - hi);
                            cursor_back = 1'b1;
                        end
                        else
                        begin
                            nxt = lo + (lo - nxt);
                            cursor_back = 1'b0;
                        end
                    end
                    pos = nxt;
                end
            end
        end
        else
        begin
            if (loop_mode >= slc_pkg::MODE_PP && cursor_back)
                cursor_back = 1'b0;
            nxt = cursor_back ? pos - step : pos + step;
            rel_lim = longint'(rel_end_idx);
            rel_lim = rel_lim << slc_pkg::FRAC_BITS;
            beat.done = (nxt >= rel_lim);
            pos = nxt;
        end

        if (pos < 0)
            cursor_pos = '0;
        else if (pos > POS_LIMIT)
            cursor_pos = '1;
        else
            cursor_pos = pos[slc_pkg::POS_BITS-1:0];

        beat.position = cursor_pos;
        beat.backward = cursor_back;
        return beat;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            loop_mode = slc_pkg::MODE_NONE;
            intro_on = 1'b0;
            start_idx = '0;
            end_idx = slc_pkg::INDEX_BITS'(1);
            rel_end_idx = slc_pkg::INDEX_BITS'(1);
            cursor_pos = '0;
            cursor_back = 1'b0;
            errors = 0;
            expected_positions.delete();
            outstanding <= 0;
        end
        else
        begin
            // The output is checked first: a beat taken at this edge cannot
            // belong to an input beat taken at the same edge.
            if (out_valid && !out_stall)
            begin
                if (expected_positions.size() == 0)
                begin
                    $error("output beat with nothing pending: read_position %h",
                           read_position);
                    errors++;
                end
                else
                begin
                    want = expected_positions.pop_front();
                    if (read_position !== want.position)
                    begin
                        $error("read_position: expected %h, got %h",
                               want.position, read_position);
                        errors++;
                    end
                    if (moving_backward !== want.backward)
                    begin
                        $error("moving_backward: expected %b, got %b",
                               want.backward, moving_backward);
                        errors++;
                    end
                    if (finished !== want.done)
                    begin
                        $error("finished: expected %b, got %b", want.done, finished);
                        errors++;
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[slc_pkg::PADDR_BITS-1:2])
                    slc_pkg::REG_LOOP_MODE:   loop_mode = pwdata[slc_pkg::MODE_BITS-1:0];
                    slc_pkg::REG_INTRO_EN:    intro_on = pwdata[0];
                    slc_pkg::REG_LOOP_START:  start_idx = pwdata[slc_pkg::INDEX_BITS-1:0];
                    slc_pkg::REG_LOOP_END:    end_idx = pwdata[slc_pkg::INDEX_BITS-1:0];
                    slc_pkg::REG_RELEASE_END: rel_end_idx = pwdata[slc_pkg::INDEX_BITS-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                predicted = advance_cursor(increment, released);
                expected_positions = {expected_positions, predicted};
            end

            outstanding <= expected_positions.size();
        end
    end

endmodule

// ===== bench/sample_loop_cursor_core_test.sv =====
`timescale 1ns / 1ps

module sample_loop_cursor_core_test;

    localparam int unsigned ITEM_TARGET  = 1250;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned QUIET_LIMIT  = 4000;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [slc_pkg::PADDR_BITS-1:0] paddr;
    logic [slc_pkg::PDATA_BITS-1:0] pwdata;
    logic [slc_pkg::PDATA_BITS-1:0] prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_stall;
    logic [slc_pkg::INC_BITS-1:0]   increment;
    logic                           released;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [slc_pkg::POS_BITS-1:0]   read_position;
    logic                           moving_backward;
    logic                           finished;

    int unsigned errors;
    int unsigned outstanding;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned beats_sent = 0;
    int unsigned quiet_cycles = 0;

    logic [slc_pkg::INDEX_BITS-1:0] loop_start_now;

    sample_loop_cursor_core DUT (.*);

    cursor_position_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(negedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // Ends the run if nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // All driving tasks start and end at a falling edge.
    task automatic write_reg(input logic [slc_pkg::REG_BITS-1:0]   which,
                             input logic [slc_pkg::PDATA_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_beat(input logic [slc_pkg::INC_BITS-1:0] step, input logic rel);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        increment <= step;
        released <= rel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [slc_pkg::INC_BITS-1:0] pick_increment();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return slc_pkg::INC_BITS'($urandom_range(1, 16'hFFFF));
            3: return slc_pkg::INC_BITS'($urandom_range(1, 16)) << slc_pkg::FRAC_BITS;
            default: return slc_pkg::INC_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [slc_pkg::INDEX_BITS-1:0] pick_index();
        case ($urandom_range(7))
            0: return '0;
            1: return slc_pkg::INDEX_BITS'(1);
            2: return 24'hFFFFFE;
            3: return '1;
            4, 5: return slc_pkg::INDEX_BITS'($urandom_range(4095));
            default: return slc_pkg::INDEX_BITS'($urandom());
        endcase
    endfunction

    initial
    begin
        int unsigned target;
        int unsigned count;
        int unsigned hold;
        int unsigned phase;
        logic [slc_pkg::INDEX_BITS-1:0] end_pick;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        increment = '0;
        released = 1'b0;
        loop_start_now = '0;
        idle_pct = 6;
        stall_pct = 6;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: free running, release end at one sample.
        send_beat('0, 1'b0);
        send_beat('1, 1'b1);

        // One-sample forward loop at zero; a far cursor hits the wrap limit.
        wait_idle();
        write_reg(slc_pkg::REG_LOOP_MODE, slc_pkg::PDATA_BITS'(slc_pkg::MODE_FWD));
        write_reg(slc_pkg::REG_LOOP_START, 0);
        write_reg(slc_pkg::REG_LOOP_END, 1);
        send_beat(24'h00FFFF, 1'b0);
        repeat (4) send_beat(24'h000001, 1'b0);

        // Intro from below the loop; the second step crosses loop end.
        wait_idle();
        write_reg(slc_pkg::REG_LOOP_MODE, slc_pkg::PDATA_BITS'(slc_pkg::MODE_PP));
        write_reg(slc_pkg::REG_INTRO_EN, 1);
        write_reg(slc_pkg::REG_LOOP_START, 8);
        write_reg(slc_pkg::REG_LOOP_END, 10);
        send_beat(24'h050000, 1'b0);
        send_beat(24'h050000, 1'b0);
        send_beat(24'h008000, 1'b0);

        // Backward flag left over in free running drives the cursor below zero.
        wait_idle();
        write_reg(slc_pkg::REG_LOOP_MODE, slc_pkg::PDATA_BITS'(slc_pkg::MODE_NONE));
        send_beat('1, 1'b0);

        // Released in ping-pong clears the flag, then a reflection off loop start.
        wait_idle();
        write_reg(slc_pkg::REG_LOOP_MODE, slc_pkg::PDATA_BITS'(slc_pkg::MODE_PP));
        write_reg(slc_pkg::REG_INTRO_EN, 0);
        write_reg(slc_pkg::REG_LOOP_START, slc_pkg::PDATA_BITS'(24'h600000));
        write_reg(slc_pkg::REG_LOOP_END, slc_pkg::PDATA_BITS'(24'hFFFFFF));
        send_beat(24'h00000A, 1'b1);
        send_beat('0, 1'b0);

        // The unused mode code acts as ping-pong and lifts the cursor near the top.
        wait_idle();
        write_reg(slc_pkg::REG_LOOP_MODE,
                  slc_pkg::PDATA_BITS'(slc_pkg::MODE_PP | slc_pkg::MODE_FWD));
        write_reg(slc_pkg::REG_LOOP_START, slc_pkg::PDATA_BITS'(24'hDFFFF8));
        send_beat(24'h000001, 1'b0);

        // Free running past the largest position clamps and flags the end.
        wait_idle();
        write_reg(slc_pkg::REG_LOOP_MODE, slc_pkg::PDATA_BITS'(slc_pkg::MODE_NONE));
        write_reg(slc_pkg::REG_RELEASE_END, slc_pkg::PDATA_BITS'(24'hFFFFFF));
        send_beat('1, 1'b1);
        send_beat('1, 1'b1);
        send_beat('1, 1'b0);

        // Loop start at the top index pushes loop end past the largest position.
        wait_idle();
        write_reg(slc_pkg::REG_LOOP_MODE, slc_pkg::PDATA_BITS'(slc_pkg::MODE_FWD));
        write_reg(slc_pkg::REG_LOOP_START, slc_pkg::PDATA_BITS'(24'hFFFFFF));
        write_reg(slc_pkg::REG_LOOP_END, 0);
        send_beat('1, 1'b0);
        loop_start_now = '1;

        phase = 0;
        while (beats_sent < ITEM_TARGET)
        begin
            wait_idle();
            case (phase % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 50;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 50;
                end
                default:
                begin
                    idle_pct = 6;
                    stall_pct = 6;
                end
            endcase

            if ($urandom_range(99) < 70)
                write_reg(slc_pkg::REG_LOOP_MODE, slc_pkg::PDATA_BITS'($urandom_range(3)));
            if ($urandom_range(99) < 50)
                write_reg(slc_pkg::REG_INTRO_EN, slc_pkg::PDATA_BITS'($urandom_range(1)));
            if ($urandom_range(99) < 60)
            begin
                loop_start_now = pick_index();
                write_reg(slc_pkg::REG_LOOP_START, slc_pkg::PDATA_BITS'(loop_start_now));
            end
            if ($urandom_range(99) < 60)
            begin
                case ($urandom_range(5))
                    0: end_pick = '0;
                    1: end_pick = loop_start_now;
                    2: end_pick = loop_start_now
                                  + slc_pkg::INDEX_BITS'($urandom_range(1, 4));
                    3: end_pick = '1;
                    4: end_pick = slc_pkg::INDEX_BITS'($urandom());
                    default: end_pick = loop_start_now
                                        + slc_pkg::INDEX_BITS'($urandom_range(1, 4096));
                endcase
                write_reg(slc_pkg::REG_LOOP_END, slc_pkg::PDATA_BITS'(end_pick));
            end
            if ($urandom_range(99) < 40)
                write_reg(slc_pkg::REG_RELEASE_END, slc_pkg::PDATA_BITS'(pick_index()));

            // Notes: a held stretch with an odd stray release, then a release tail.
            target = $urandom_range(50, 110);
            count = 0;
            while (count < target)
            begin
                hold = $urandom_range(1, 40);
                repeat (hold)
                begin
                    send_beat(pick_increment(), $urandom_range(19) == 0);
                    count++;
                end
                hold = $urandom_range(0, 8);
                repeat (hold)
                begin
                    send_beat(pick_increment(), 1'b1);
                    count++;
                end
            end
            phase++;
        end

        wait_idle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
